/* rtl/owm_pkg.sv */
// Shared types, constants and helper functions for the 1-Wire bus master.
// Used by owm_core and one_wire_bus_master_top; depends on nothing else.
package owm_pkg;

    // Sequence phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_W_REC    = 4'd6,
        PH_R_START  = 4'd7,
        PH_R_WAIT   = 4'd8,
        PH_R_REC    = 4'd9
    } phase_t;

    // Command codes
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_CONVERT = 2'd1;
    localparam logic [1:0] OP_RD_ROM  = 2'd2;
    localparam logic [1:0] OP_RD_SCR  = 2'd3;

    // 1-Wire command bytes
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT_T  = 8'h44;
    localparam logic [7:0] CMD_READ_ROM   = 8'h33;
    localparam logic [7:0] CMD_READ_SCR   = 8'hBE;
    localparam logic [7:0] CRC_POLY       = 8'h8C;

    localparam logic [3:0] ROM_BYTES        = 4'd8;
    localparam int unsigned SCRATCH_BYTES_DEF = 9;

    // Register indexes
    localparam logic [2:0] REG_RESET_LOW      = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [2:0] REG_SLOT_START_LOW = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD     = 3'd4;
    localparam logic [2:0] REG_WRITE_RECOVERY = 3'd5;
    localparam logic [2:0] REG_READ_RELEASE   = 3'd6;
    localparam logic [2:0] REG_READ_RECOVERY  = 3'd7;

    // Register reset values
    localparam logic [9:0] RESET_LOW_DEF      = 10'd500;
    localparam logic [9:0] PRESENCE_WAIT_DEF  = 10'd70;
    localparam logic [9:0] RESET_TAIL_DEF     = 10'd430;
    localparam logic [5:0] SLOT_START_LOW_DEF = 6'd2;
    localparam logic [7:0] WRITE_HOLD_DEF     = 8'd15;
    localparam logic [7:0] WRITE_RECOVERY_DEF = 8'd40;
    localparam logic [5:0] READ_RELEASE_DEF   = 6'd3;
    localparam logic [7:0] READ_RECOVERY_DEF  = 8'd50;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_wait;
        logic [9:0] reset_tail;
        logic [5:0] slot_start_low;
        logic [7:0] write_hold;
        logic [7:0] write_recovery;
        logic [5:0] read_release;
        logic [7:0] read_recovery;
    } cfg_t;

    typedef struct packed {
        logic [3:0] byte_index;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       crc_ok;
        logic       present;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    // Dallas CRC-8, reflected, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [1:0] cmd, input logic idx);
        logic [7:0] b;
        case (cmd)
            OP_CONVERT: b = idx ? CMD_CONVERT_T : CMD_SKIP_ROM;
            OP_RD_ROM:  b = idx ? 8'h00 : CMD_READ_ROM;
            OP_RD_SCR:  b = idx ? CMD_READ_SCR : CMD_SKIP_ROM;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] cmd_len(input logic [1:0] cmd);
        logic [3:0] n;
        case (cmd)
            OP_CONVERT: n = 4'd2;
            OP_RD_SCR:  n = 4'd2;
            default:    n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

/* rtl/one_wire_bus_master_top.sv */
// One beat in per one-microsecond tick, one result beat out per input beat. The result
// is registered and appears in the cycle after its input beat is taken, and a new beat is
// taken every cycle while the output register is empty or being drained; the sequencer
// state advances once per accepted beat, so sustained rate is one beat per clock. Timing
// registers sit on an APB port at byte addresses 4*i and must be written only while no
// sequence runs. Top level of the 1-Wire bus master: stream ports, APB timing registers,
// output register. Depends on owm_pkg and owm_core.
module one_wire_bus_master_top #(
    parameter int unsigned SCRATCH_BYTES = owm_pkg::SCRATCH_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] op, [2] line_in, [7:3] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] present, [4] crc_ok,
    // [12:5] data_byte, [13] byte_valid, [17:14] byte_index, [23:18] zero
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    owm_pkg::cfg_t cfg_reg;
    owm_pkg::res_t res_comb;
    owm_pkg::res_t res_reg;
    logic          m_valid_reg;
    logic          step;
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_time <= owm_pkg::RESET_LOW_DEF;
            cfg_reg.presence_wait  <= owm_pkg::PRESENCE_WAIT_DEF;
            cfg_reg.reset_tail     <= owm_pkg::RESET_TAIL_DEF;
            cfg_reg.slot_start_low <= owm_pkg::SLOT_START_LOW_DEF;
            cfg_reg.write_hold     <= owm_pkg::WRITE_HOLD_DEF;
            cfg_reg.write_recovery <= owm_pkg::WRITE_RECOVERY_DEF;
            cfg_reg.read_release   <= owm_pkg::READ_RELEASE_DEF;
            cfg_reg.read_recovery  <= owm_pkg::READ_RECOVERY_DEF;
        end else if (cfg_wr) begin
            case (reg_idx)
                owm_pkg::REG_RESET_LOW:      cfg_reg.reset_low_time <= pwdata[9:0];
                owm_pkg::REG_PRESENCE_WAIT:  cfg_reg.presence_wait  <= pwdata[9:0];
                owm_pkg::REG_RESET_TAIL:     cfg_reg.reset_tail     <= pwdata[9:0];
                owm_pkg::REG_SLOT_START_LOW: cfg_reg.slot_start_low <= pwdata[5:0];
                owm_pkg::REG_WRITE_HOLD:     cfg_reg.write_hold     <= pwdata[7:0];
                owm_pkg::REG_WRITE_RECOVERY: cfg_reg.write_recovery <= pwdata[7:0];
                owm_pkg::REG_READ_RELEASE:   cfg_reg.read_release   <= pwdata[5:0];
                owm_pkg::REG_READ_RECOVERY:  cfg_reg.read_recovery  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            owm_pkg::REG_RESET_LOW:      prdata = 32'(cfg_reg.reset_low_time);
            owm_pkg::REG_PRESENCE_WAIT:  prdata = 32'(cfg_reg.presence_wait);
            owm_pkg::REG_RESET_TAIL:     prdata = 32'(cfg_reg.reset_tail);
            owm_pkg::REG_SLOT_START_LOW: prdata = 32'(cfg_reg.slot_start_low);
            owm_pkg::REG_WRITE_HOLD:     prdata = 32'(cfg_reg.write_hold);
            owm_pkg::REG_WRITE_RECOVERY: prdata = 32'(cfg_reg.write_recovery);
            owm_pkg::REG_READ_RELEASE:   prdata = 32'(cfg_reg.read_release);
            owm_pkg::REG_READ_RECOVERY:  prdata = 32'(cfg_reg.read_recovery);
            default:                     prdata = 32'd0;
        endcase
    end

    owm_core #(
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .op      (s_tdata[1:0]),
        .line_in (s_tdata[2]),
        .cfg     (cfg_reg),
        .res     (res_comb)
    );

    // Output register: load on every accepted beat, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_reg};

`ifndef ASSERT_OFF
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("accepted beat produced no result");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.done_res |-> res_reg.busy_res)
        else $error("done outside a sequence");

    a_crc_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.crc_ok |-> res_reg.done_res && res_reg.present)
        else $error("crc_ok without done and presence");

    a_read_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.byte_valid |-> !res_reg.drive_low && res_reg.busy_res)
        else $error("byte reported while bus driven");
`endif

endmodule

/* rtl/owm_core.sv */
// Sequencer core of the 1-Wire bus master: phase, slot timer, bit/byte counters,
// shift and CRC registers, one update per tick. Depends on owm_pkg.
module owm_core #(
    parameter int unsigned SCRATCH_BYTES = owm_pkg::SCRATCH_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [1:0]       op,
    input  logic             line_in,
    input  owm_pkg::cfg_t    cfg,
    output owm_pkg::res_t    res
);

    localparam logic [3:0] SCRATCH_TOTAL = 4'(SCRATCH_BYTES);

    owm_pkg::phase_t phase_reg, phase_next;
    logic [9:0] timer_reg, timer_next;
    logic [2:0] bit_reg, bit_next;
    logic [3:0] byte_reg, byte_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] crc_reg, crc_next;
    logic [1:0] cmd_reg, cmd_next;
    logic       pres_reg, pres_next;

    // Phase length on entry; zero counts as one tick
    function automatic logic [9:0] load_time(input owm_pkg::phase_t ph, input owm_pkg::cfg_t c);
        logic [9:0] t;
        case (ph)
            owm_pkg::PH_RST_LOW:  t = c.reset_low_time;
            owm_pkg::PH_RST_WAIT: t = c.presence_wait;
            owm_pkg::PH_RST_TAIL: t = c.reset_tail;
            owm_pkg::PH_W_START:  t = 10'(c.slot_start_low);
            owm_pkg::PH_W_HOLD:   t = 10'(c.write_hold);
            owm_pkg::PH_W_REC:    t = 10'(c.write_recovery);
            owm_pkg::PH_R_START:  t = 10'(c.slot_start_low);
            owm_pkg::PH_R_WAIT:   t = 10'(c.read_release);
            owm_pkg::PH_R_REC:    t = 10'(c.read_recovery);
            default:              t = 10'd1;
        endcase
        if (t == 10'd0) begin
            t = 10'd1;
        end
        return t;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owm_pkg::PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            crc_reg   <= '0;
            cmd_reg   <= owm_pkg::OP_NONE;
            pres_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            pres_reg  <= pres_next;
        end
    end

    always_comb begin
        logic [3:0] total;
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        pres_next  = pres_reg;
        res        = '0;
        total      = (cmd_reg == owm_pkg::OP_RD_ROM) ? owm_pkg::ROM_BYTES : SCRATCH_TOTAL;

        if (phase_reg != owm_pkg::PH_IDLE || op != owm_pkg::OP_NONE) begin
            if (phase_reg == owm_pkg::PH_IDLE) begin
                cmd_next   = op;
                crc_next   = '0;
                pres_next  = 1'b0;
                byte_next  = '0;
                bit_next   = '0;
                shift_next = '0;
                phase_next = owm_pkg::PH_RST_LOW;
                timer_next = load_time(owm_pkg::PH_RST_LOW, cfg);
            end

            res.busy_res  = 1'b1;
            res.drive_low = (phase_next == owm_pkg::PH_RST_LOW)
                         || (phase_next == owm_pkg::PH_W_START)
                         || (phase_next == owm_pkg::PH_R_START)
                         || (phase_next == owm_pkg::PH_W_HOLD && !shift_next[0]);

            timer_next = timer_next - 10'd1;
            if (timer_next == 10'd0) begin
                case (phase_next)
                    owm_pkg::PH_RST_LOW: begin
                        phase_next = owm_pkg::PH_RST_WAIT;
                    end
                    owm_pkg::PH_RST_WAIT: begin
                        pres_next  = !line_in;
                        phase_next = owm_pkg::PH_RST_TAIL;
                    end
                    owm_pkg::PH_RST_TAIL: begin
                        if (!pres_next) begin
                            res.done_res = 1'b1;
                            phase_next   = owm_pkg::PH_IDLE;
                        end else begin
                            byte_next  = '0;
                            bit_next   = '0;
                            shift_next = owm_pkg::cmd_byte(cmd_next, 1'b0);
                            phase_next = owm_pkg::PH_W_START;
                        end
                    end
                    owm_pkg::PH_W_START: begin
                        phase_next = owm_pkg::PH_W_HOLD;
                    end
                    owm_pkg::PH_W_HOLD: begin
                        phase_next = owm_pkg::PH_W_REC;
                    end
                    owm_pkg::PH_W_REC: begin
                        shift_next = shift_next >> 1;
                        if (bit_next == 3'd7) begin
                            bit_next  = '0;
                            byte_next = byte_next + 4'd1;
                            if (byte_next < owm_pkg::cmd_len(cmd_next)) begin
                                shift_next = owm_pkg::cmd_byte(cmd_next, byte_next[0]);
                                phase_next = owm_pkg::PH_W_START;
                            end else if (cmd_next == owm_pkg::OP_CONVERT) begin
                                res.done_res = 1'b1;
                                res.present  = 1'b1;
                                phase_next   = owm_pkg::PH_IDLE;
                            end else begin
                                byte_next  = '0;
                                shift_next = '0;
                                phase_next = owm_pkg::PH_R_START;
                            end
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = owm_pkg::PH_W_START;
                        end
                    end
                    owm_pkg::PH_R_START: begin
                        phase_next = owm_pkg::PH_R_WAIT;
                    end
                    owm_pkg::PH_R_WAIT: begin
                        shift_next = {line_in, shift_next[7:1]};
                        phase_next = owm_pkg::PH_R_REC;
                    end
                    owm_pkg::PH_R_REC: begin
                        if (bit_next == 3'd7) begin
                            bit_next       = '0;
                            crc_next       = owm_pkg::crc8_byte(crc_next, shift_next);
                            res.byte_valid = 1'b1;
                            res.data_byte  = shift_next;
                            res.byte_index = byte_next;
                            byte_next      = byte_next + 4'd1;
                            if (byte_next >= total || byte_next == 4'd0) begin
                                res.done_res = 1'b1;
                                res.present  = 1'b1;
                                res.crc_ok   = (crc_next == 8'h00);
                                phase_next   = owm_pkg::PH_IDLE;
                            end else begin
                                phase_next = owm_pkg::PH_R_START;
                            end
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = owm_pkg::PH_R_START;
                        end
                    end
                    default: begin
                        phase_next = owm_pkg::PH_IDLE;
                    end
                endcase
                if (phase_next != owm_pkg::PH_IDLE) begin
                    timer_next = load_time(phase_next, cfg);
                end
            end
        end
    end

endmodule
